### hdl/aer_pkg.sv
`timescale 1ns / 1ps
// aer_pkg: shared types, round commands, s-box table and field arithmetic for the aes round
package aer_pkg;

    localparam int COL_W  = 32;
    localparam int NCOL   = 4;
    localparam int NROW   = 4;
    localparam int BYTE_W = 8;

    typedef logic [COL_W-1:0]            t_col;
    typedef logic [NCOL-1:0][COL_W-1:0]  t_state;
    typedef logic [BYTE_W-1:0]           t_byte;

    typedef enum logic [1:0] {
        CMD_ADDKEY = 2'd0,
        CMD_MIDDLE = 2'd1,
        CMD_FINAL  = 2'd2
    } t_cmd;

    localparam t_byte GF_POLY = 8'h1B;

    localparam t_byte SBOX [256] = '{
        8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
        8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
        8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
        8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
        8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
        8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
        8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
        8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
        8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
        8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
        8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
        8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
        8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
        8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
        8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
        8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
        8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
        8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
        8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
        8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
        8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
        8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
        8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
        8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
        8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
        8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
        8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
        8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
        8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
        8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
    };

    function automatic t_byte xtime8(input t_byte v);
        t_byte t;
        t = {v[BYTE_W-2:0], 1'b0};
        return v[BYTE_W-1] ? (t ^ GF_POLY) : t;
    endfunction

endpackage

### hdl/aer_if.sv
`timescale 1ns / 1ps
// aer_req_if / aer_rsp_if: valid-ready channels for round requests and results

interface aer_req_if;
    logic             valid;
    logic             ready;
    logic [1:0]       command;
    aer_pkg::t_col    state_col0;
    aer_pkg::t_col    state_col1;
    aer_pkg::t_col    state_col2;
    aer_pkg::t_col    state_col3;
    aer_pkg::t_col    key_col0;
    aer_pkg::t_col    key_col1;
    aer_pkg::t_col    key_col2;
    aer_pkg::t_col    key_col3;

    modport source (
        output valid, command, state_col0, state_col1, state_col2, state_col3,
               key_col0, key_col1, key_col2, key_col3,
        input  ready
    );
    modport sink (
        input  valid, command, state_col0, state_col1, state_col2, state_col3,
               key_col0, key_col1, key_col2, key_col3,
        output ready
    );
endinterface

interface aer_rsp_if;
    logic             valid;
    logic             ready;
    aer_pkg::t_col    out_col0;
    aer_pkg::t_col    out_col1;
    aer_pkg::t_col    out_col2;
    aer_pkg::t_col    out_col3;

    modport source (
        output valid, out_col0, out_col1, out_col2, out_col3,
        input  ready
    );
    modport sink (
        input  valid, out_col0, out_col1, out_col2, out_col3,
        output ready
    );
endinterface

### hdl/aes_encrypt_round.sv
`timescale 1ns / 1ps
// aes_encrypt_round: registered single aes encryption round with valid-ready channels
//
//  channel | dir | payload                                        | bits
//  i_req   | in  | command, state_col0..3, key_col0..3             | 2 + 8 x 32
//  o_rsp   | out | out_col0..3                                    | 4 x 32
//
//  one request per cycle sustained while o_rsp.ready holds; the path from acceptance to result is
//  input register, then s-box, mix columns and key add into the result register
//  reset empties both register stages; no payload state is kept between requests
//  a stalled result holds while a new request can still enter an empty input register
//  i_req.ready depends combinationally on o_rsp.ready
module aes_encrypt_round (
    input  logic           i_clk,
    input  logic           i_rst_n,
    aer_req_if.sink        i_req,
    aer_rsp_if.source      o_rsp
);
    import aer_pkg::*;

    logic        r_s1_valid, n_s1_valid;
    logic [1:0]  r_s1_cmd;
    t_state      r_s1_state;
    t_state      r_s1_key;
    logic        r_s2_valid, n_s2_valid;
    t_state      r_s2_col;

    t_state      subbed;
    t_state      result;
    logic        s2_adv;
    logic        s1_adv;
    logic        in_acc;

    aer_sub_shift u_sub_shift (
        .i_state (r_s1_state),
        .o_state (subbed)
    );

    aer_mix_key u_mix_key (
        .i_command (r_s1_cmd),
        .i_state   (r_s1_state),
        .i_subbed  (subbed),
        .i_key     (r_s1_key),
        .o_result  (result)
    );

    assign s2_adv      = !r_s2_valid || o_rsp.ready;
    assign s1_adv      = r_s1_valid && s2_adv;
    assign i_req.ready = !r_s1_valid || s2_adv;
    assign in_acc      = i_req.valid && i_req.ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s2_valid = r_s2_valid;
        if (i_req.ready) begin
            n_s1_valid = i_req.valid;
        end
        if (s2_adv) begin
            n_s2_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd   <= i_req.command;
            r_s1_state <= {i_req.state_col3, i_req.state_col2,
                           i_req.state_col1, i_req.state_col0};
            r_s1_key   <= {i_req.key_col3, i_req.key_col2,
                           i_req.key_col1, i_req.key_col0};
        end
        if (s1_adv) begin
            r_s2_col <= result;
        end
    end

    assign o_rsp.valid    = r_s2_valid;
    assign o_rsp.out_col0 = r_s2_col[0];
    assign o_rsp.out_col1 = r_s2_col[1];
    assign o_rsp.out_col2 = r_s2_col[2];
    assign o_rsp.out_col3 = r_s2_col[3];

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted request not held in input register");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_s2_valid)
        else $error("advanced request lost before result register");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ready && !r_s1_valid) |=> !r_s2_valid)
        else $error("result repeated after it was taken");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_s1_valid && !r_s2_valid) |-> i_req.ready)
        else $error("empty pipeline refuses requests");

endmodule

### hdl/aer_sub_shift.sv
`timescale 1ns / 1ps
// aer_sub_shift: byte substitution through the s-box with the row rotation folded in
module aer_sub_shift (
    input  aer_pkg::t_state i_state,
    output aer_pkg::t_state o_state
);
    import aer_pkg::*;

    for (genvar c = 0; c < NCOL; c++) begin : g_col
        for (genvar r = 0; r < NROW; r++) begin : g_row
            localparam int SRC = (c + r) % NCOL;
            localparam int HI  = COL_W - 1 - BYTE_W * r;
            assign o_state[c][HI -: BYTE_W] = SBOX[i_state[SRC][HI -: BYTE_W]];
        end
    end

endmodule

### hdl/aer_mix_key.sv
`timescale 1ns / 1ps
// aer_mix_key: column mixing, round-type selection and round key addition
module aer_mix_key (
    input  logic [1:0]      i_command,
    input  aer_pkg::t_state i_state,
    input  aer_pkg::t_state i_subbed,
    input  aer_pkg::t_state i_key,
    output aer_pkg::t_state o_result
);
    import aer_pkg::*;

    t_state mixed;
    t_state chosen;

    for (genvar c = 0; c < NCOL; c++) begin : g_mix
        t_byte a0, a1, a2, a3;
        t_byte d0, d1, d2, d3;
        assign a0 = i_subbed[c][31:24];
        assign a1 = i_subbed[c][23:16];
        assign a2 = i_subbed[c][15:8];
        assign a3 = i_subbed[c][7:0];
        assign d0 = xtime8(a0);
        assign d1 = xtime8(a1);
        assign d2 = xtime8(a2);
        assign d3 = xtime8(a3);
        assign mixed[c][31:24] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
        assign mixed[c][23:16] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
        assign mixed[c][15:8]  = a0 ^ a1 ^ d2 ^ d3 ^ a3;
        assign mixed[c][7:0]   = d0 ^ a0 ^ a1 ^ a2 ^ d3;
    end

    // unused command code behaves as key addition only
    always_comb begin
        unique case (i_command)
            CMD_MIDDLE: chosen = mixed;
            CMD_FINAL:  chosen = i_subbed;
            default:    chosen = i_state;
        endcase
    end

    assign o_result = chosen ^ i_key;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for the aes encryption round, predicted results against the uut

module tb;
    import aer_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam t_col       ALL_ONES   = 32'hFFFF_FFFF;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic rst_done = 1'b0;
    logic steady   = 1'b0;

    aer_req_if req_if ();
    aer_rsp_if rsp_if ();

    aes_encrypt_round uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_byte  sub_lut [256];
    t_state pending_rounds [$];
    int     n_errors  = 0;
    int     n_checked = 0;
    int     n_by_cmd [4] = '{0, 0, 0, 0};
    int     stall_left = 0;

    always #5 i_clk = ~i_clk;

    function automatic t_byte gf_double(input t_byte v);
        return v[7] ? ({v[6:0], 1'b0} ^ 8'h1B) : {v[6:0], 1'b0};
    endfunction

    function automatic t_byte gf_mul(input t_byte a, input t_byte b);
        t_byte p;
        t_byte x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = gf_double(x);
        end
        return p;
    endfunction

    // s-box from the field inverse and the affine map
    task automatic build_sub_lut();
        t_byte inv;
        t_byte b;
        for (int v = 0; v < 256; v++) begin
            inv = 8'h01;
            for (int i = 0; i < 254; i++) inv = gf_mul(inv, t_byte'(v));
            b = inv;
            sub_lut[v] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                       ^ {b[3:0], b[7:4]} ^ 8'h63;
        end
    endtask

    function automatic t_state aes_round_predict(input logic [1:0] cmd, input t_state st,
                                                 input t_state rk);
        t_byte  m [4][4];
        t_byte  s [4][4];
        t_byte  d [4];
        t_state res;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                m[r][c] = st[c][8*(3-r) +: 8];
        if (cmd == CMD_MIDDLE || cmd == CMD_FINAL) begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    s[r][c] = sub_lut[m[r][(c + r) % 4]];
            for (int c = 0; c < 4; c++) begin
                if (cmd == CMD_MIDDLE) begin
                    for (int r = 0; r < 4; r++) d[r] = gf_double(s[r][c]);
                    m[0][c] = d[0] ^ d[1] ^ s[1][c] ^ s[2][c] ^ s[3][c];
                    m[1][c] = s[0][c] ^ d[1] ^ d[2] ^ s[2][c] ^ s[3][c];
                    m[2][c] = s[0][c] ^ s[1][c] ^ d[2] ^ d[3] ^ s[3][c];
                    m[3][c] = d[0] ^ s[0][c] ^ s[1][c] ^ s[2][c] ^ d[3];
                end else begin
                    for (int r = 0; r < 4; r++) m[r][c] = s[r][c];
                end
            end
        end
        for (int c = 0; c < 4; c++)
            res[c] = {m[0][c], m[1][c], m[2][c], m[3][c]} ^ rk[c];
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom_range(20, 60);
        if (r < 10) return 0;
        return $urandom_range(1, 3);
    endfunction

    function automatic t_col rand_col();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return ALL_ONES;
            2: return {4{8'h80}} ^ {4{t_byte'($urandom_range(0, 1))}};
            default: return $urandom;
        endcase
    endfunction

    function automatic t_state rand_block();
        t_state b;
        for (int c = 0; c < 4; c++) b[c] = rand_col();
        return b;
    endfunction

    task automatic send_round(input logic [1:0] cmd, input t_state st, input t_state rk);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.command    <= cmd;
        req_if.state_col0 <= st[0];
        req_if.state_col1 <= st[1];
        req_if.state_col2 <= st[2];
        req_if.state_col3 <= st[3];
        req_if.key_col0   <= rk[0];
        req_if.key_col1   <= rk[1];
        req_if.key_col2   <= rk[2];
        req_if.key_col3   <= rk[3];
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        pending_rounds.push_back(aes_round_predict(cmd, st, rk));
        n_by_cmd[cmd]++;
    endtask

    // result check and random back-pressure
    always @(posedge i_clk) begin
        if (rst_done) begin
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                t_state got;
                t_state want;
                got = {rsp_if.out_col3, rsp_if.out_col2, rsp_if.out_col1, rsp_if.out_col0};
                if (pending_rounds.size() == 0) begin
                    $error("result with no request pending: %h", got);
                    n_errors++;
                end else begin
                    want = pending_rounds.pop_front();
                    for (int c = 0; c < 4; c++) begin
                        if (got[c] !== want[c]) begin
                            $error("out_col%0d expected %h actual %h", c, want[c], got[c]);
                            n_errors++;
                        end
                    end
                    n_checked++;
                end
            end
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end else begin
                rsp_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
            end
        end
    end

    task automatic test_key_whitening();
        send_round(CMD_ADDKEY, '0, '0);
        send_round(CMD_ADDKEY, {4{ALL_ONES}}, {4{ALL_ONES}});
        send_round(CMD_ADDKEY, {4{ALL_ONES}}, '0);
        send_round(CMD_ADDKEY, '0, {4{ALL_ONES}});
        send_round(CMD_ADDKEY, {4{32'hA5A5_5A5A}}, {4{32'h5A5A_A5A5}});
    endtask

    task automatic test_unused_command();
        send_round(CMD_UNUSED, {4{ALL_ONES}}, '0);
        send_round(CMD_UNUSED, rand_block(), rand_block());
    endtask

    task automatic test_middle_round();
        send_round(CMD_MIDDLE, '0, '0);
        send_round(CMD_MIDDLE, {4{ALL_ONES}}, {4{ALL_ONES}});
        send_round(CMD_MIDDLE, {4{32'h8080_8080}}, '0);
        send_round(CMD_MIDDLE, {32'hE9F8_4808, 32'h9AC6_8D2A, 32'hA0F4_E22B, 32'h193D_E3BE},
                   {32'h2A6C_7605, 32'h23A3_3939, 32'h8854_2CB1, 32'hA0FA_FE17});
    endtask

    task automatic test_final_round();
        send_round(CMD_FINAL, '0, '0);
        send_round(CMD_FINAL, {4{ALL_ONES}}, {4{ALL_ONES}});
        send_round(CMD_FINAL, {32'h1E84_E7D2, 32'hF238_1342, 32'h402E_A1C3, 32'hEB59_8B1B},
                   {32'hB663_0CA6, 32'hE13F_0CC8, 32'hC9EE_2589, 32'hD014_F9A8});
    endtask

    // whitening, nine middle rounds and a final round, each fed the predicted state
    task automatic test_cipher_chains(input int n_chains);
        t_state st;
        t_state rk;
        logic [1:0] cmd;
        for (int n = 0; n < n_chains; n++) begin
            steady = ($urandom_range(0, 4) == 0);
            st = rand_block();
            for (int rnd = 0; rnd <= 10; rnd++) begin
                cmd = (rnd == 0) ? CMD_ADDKEY : (rnd == 10) ? CMD_FINAL : CMD_MIDDLE;
                rk  = rand_block();
                send_round(cmd, st, rk);
                st = aes_round_predict(cmd, st, rk);
            end
        end
        steady = 1'b0;
    endtask

    task automatic test_random_rounds(input int n_items);
        logic [1:0] cmd;
        for (int n = 0; n < n_items; n++) begin
            if (n % 100 == 0) steady = ($urandom_range(0, 3) == 0);
            cmd = 2'($urandom_range(0, 3));
            send_round(cmd, rand_block(), rand_block());
        end
        steady = 1'b0;
    endtask

    initial begin
        req_if.valid      = 1'b0;
        req_if.command    = CMD_ADDKEY;
        req_if.state_col0 = '0;
        req_if.state_col1 = '0;
        req_if.state_col2 = '0;
        req_if.state_col3 = '0;
        req_if.key_col0   = '0;
        req_if.key_col1   = '0;
        req_if.key_col2   = '0;
        req_if.key_col3   = '0;
        rsp_if.ready      = 1'b0;
        build_sub_lut();
        repeat (3) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done <= 1'b1;
        @(posedge i_clk);

        test_key_whitening();
        test_unused_command();
        test_middle_round();
        test_final_round();
        test_cipher_chains(100);
        test_random_rounds(590);

        req_if.valid <= 1'b0;
        while (pending_rounds.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("sent %0d key-add, %0d middle, %0d final and %0d unused-code requests",
                 n_by_cmd[0], n_by_cmd[1], n_by_cmd[2], n_by_cmd[3]);
        $display("checked %0d results, including 100 chained full encryptions", n_checked);
        if (n_errors == 0 && pending_rounds.size() == 0) begin
            $display("** aes_encrypt_round: PASSED **");
        end else begin
            $display("** aes_encrypt_round: FAILED **");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("** aes_encrypt_round: FAILED **");
        $finish;
    end

endmodule

### sim.f
hdl/aer_pkg.sv
hdl/aer_if.sv
hdl/aer_sub_shift.sv
hdl/aer_mix_key.sv
hdl/aes_encrypt_round.sv
tb/tb.sv
